FILE: rtl/core/sts_pkg.sv
// Shared constants for the AML sleep type scanner: opcodes, name bytes and defaults.
package sts_pkg;

  localparam int STS_WINDOW_BYTES = 14;

  localparam logic [7:0] NAME_OP     = 8'h08;
  localparam logic [7:0] PACKAGE_OP  = 8'h12;
  localparam logic [7:0] BYTE_PREFIX = 8'h0A;
  localparam logic [7:0] WORD_PREFIX = 8'h0B;
  localparam logic [7:0] ZERO_OP     = 8'h00;
  localparam logic [7:0] ONE_OP      = 8'h01;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_S          = 8'h53;
  localparam logic [7:0] CHAR_FIVE       = 8'h35;

  // Offset of the package length byte, and of the value byte when no extra length bytes follow.
  localparam logic [3:0] PKG_LEN_OFS = 4'd6;
  localparam logic [3:0] VALUE_OFS   = 4'd8;

endpackage

FILE: rtl/core/aml_sleep_type_scanner_core.sv
// AML _S5_ sleep type scanner: window over the byte stream, candidate tests, result register.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+---------------------------
//   input   | byte_valid   | byte_stall   | data_byte, last_byte
//   output  | result_valid | result_stall | found, sleep_type
//
// One input item per cycle while byte_stall is low: window update and all candidate tests
// finish in the cycle of acceptance, and the result for the item with last_byte is
// registered onto result_valid. A result that meets a stalled output parks in a spare
// register; byte_stall is that spare's valid, so input stalls only with two results held.
// Synchronous reset clears fill count, match latch and both result valids; the window
// bytes need no reset since no test reads past the filled part.
module aml_sleep_type_scanner_core
  import sts_pkg::*;
#(
  parameter int WINDOW_BYTES = STS_WINDOW_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       found,
  output logic [2:0] sleep_type
);

  localparam int CNTW = $clog2(WINDOW_BYTES + 1);
  localparam int EXT_BYTES = WINDOW_BYTES + 13;
  localparam int XW = $clog2(EXT_BYTES);
  localparam logic [CNTW-1:0] FULL = CNTW'(WINDOW_BYTES);

  // Window, oldest byte first, and how many entries are filled.
  logic [7:0]      window      [WINDOW_BYTES];
  logic [7:0]      window_next [WINDOW_BYTES];
  logic [CNTW-1:0] fill;
  logic [CNTW-1:0] fill_next;
  logic            match_seen;
  logic [2:0]      match_type;

  // Window after this item, padded with zeros so fixed-offset reads never leave the array.
  logic [7:0] ext [EXT_BYTES];

  logic                    accept;
  logic [WINDOW_BYTES-1:0] cand_hit;
  logic [2:0]              cand_type [WINDOW_BYTES];
  logic                    scan_hit;
  logic [2:0]              scan_type;

  // Result for the stream that closes with this item.
  logic                    report_found;
  logic [2:0]              report_type;

  // Spare result, held behind a result the consumer stalls.
  logic                    spare_valid;
  logic                    spare_found;
  logic [2:0]              spare_type;

  // Hold the input only while the spare result register is occupied.
  assign byte_stall = spare_valid;
  assign accept     = byte_valid & ~byte_stall;

  // Shift once the window is full, else append at the fill position.
  always_comb begin
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      if (fill == FULL) begin
        window_next[k] = (k == WINDOW_BYTES - 1) ? data_byte : window[(k + 1) % WINDOW_BYTES];
      end else begin
        window_next[k] = (CNTW'(k) == fill) ? data_byte : window[k];
      end
    end
    fill_next = (fill == FULL) ? FULL : fill + CNTW'(1);
  end

  for (genvar k = 0; k < EXT_BYTES; k++) begin : g_ext
    if (k < WINDOW_BYTES) begin : g_win
      assign ext[k] = window_next[k];
    end else begin : g_pad
      assign ext[k] = 8'h00;
    end
  end

  // One tester per window offset. Mid-stream only the oldest offset is tested,
  // against a full window; on the final byte every filled offset is tested.
  for (genvar o = 0; o < WINDOW_BYTES; o++) begin : g_cand
    logic            enable;
    logic [CNTW-1:0] rem;
    logic            head_ok;
    logic [1:0]      extra;
    logic [3:0]      q;
    logic [XW-1:0]   vidx;
    logic [7:0]      vbyte;
    logic [7:0]      obyte;
    logic            hit;
    logic [2:0]      htype;

    assign enable = ~match_seen &
                    (last_byte ? (CNTW'(o) < fill_next) : ((o == 0) && (fill_next == FULL)));
    assign rem    = last_byte ? (fill_next - CNTW'(o)) : FULL;

    assign head_ok = (ext[o]     == NAME_OP)         && (ext[o + 1] == CHAR_UNDERSCORE) &&
                     (ext[o + 2] == CHAR_S)          && (ext[o + 3] == CHAR_FIVE) &&
                     (ext[o + 4] == CHAR_UNDERSCORE) && (ext[o + 5] == PACKAGE_OP);

    // Skip the extra length bytes and the element count.
    assign extra = ext[o + int'(PKG_LEN_OFS)][7:6];
    assign q     = VALUE_OFS + {2'b00, extra};
    assign vidx  = XW'(o) + XW'(q);
    assign vbyte = ext[vidx];
    assign obyte = ext[vidx + XW'(1)];

    always_comb begin
      hit   = 1'b0;
      htype = 3'd0;
      if (enable && head_ok && (CNTW'(q) < rem)) begin
        if (vbyte == BYTE_PREFIX && (CNTW'(q) + CNTW'(1)) < rem) begin
          hit   = 1'b1;
          htype = obyte[2:0];
        end else if (vbyte == ZERO_OP) begin
          hit   = 1'b1;
          htype = 3'd0;
        end else if (vbyte == ONE_OP) begin
          hit   = 1'b1;
          htype = 3'd1;
        end else if (vbyte == WORD_PREFIX && (CNTW'(q) + CNTW'(2)) < rem) begin
          hit   = 1'b1;
          htype = obyte[2:0];
        end
      end
    end

    assign cand_hit[o]  = hit;
    assign cand_type[o] = htype;
  end

  // The oldest matching offset wins.
  always_comb begin
    scan_hit  = 1'b0;
    scan_type = 3'd0;
    for (int i = WINDOW_BYTES - 1; i >= 0; i--) begin
      if (cand_hit[i]) begin
        scan_hit  = 1'b1;
        scan_type = cand_type[i];
      end
    end
  end

  assign report_found = match_seen | scan_hit;
  assign report_type  = match_seen ? match_type : scan_type;

  // Window bytes: advance on every accepted item; contents past the fill count are never read.
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      match_seen   <= 1'b0;
      match_type   <= 3'd0;
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          // Start over for the next stream.
          fill       <= '0;
          match_seen <= 1'b0;
          match_type <= 3'd0;
        end else begin
          fill <= fill_next;
          if (scan_hit) begin
            match_seen <= 1'b1;
            match_type <= scan_type;
          end
        end
      end
      if (accept && last_byte) begin
        if (result_valid && result_stall) begin
          // Park the new result behind the one the consumer holds.
          spare_valid <= 1'b1;
          spare_found <= report_found;
          spare_type  <= report_type;
        end else begin
          result_valid <= 1'b1;
          found        <= report_found;
          sleep_type   <= report_type;
        end
      end else if (result_valid && !result_stall) begin
        // Drop the taken result, or advance the parked one into its place.
        result_valid <= spare_valid;
        spare_valid  <= 1'b0;
        if (spare_valid) begin
          found      <= spare_found;
          sleep_type <= spare_type;
        end
      end
    end
  end

endmodule

FILE: tb/tb_aml_sleep_type_scanner_core.sv
// Self-checking testbench for the AML _S5_ sleep type scanner core.
module tb_aml_sleep_type_scanner_core;
  import sts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = STS_WINDOW_BYTES;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic       found;
    logic [2:0] stype;
  } scan_result_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed;
    scan_result_t res;
  } stim_row_t;

  typedef bit [7:0] byte_q_t[$];

  logic       clk = 1'b0;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       result_valid;
  logic       result_stall;
  logic       found;
  logic [2:0] sleep_type;

  // Scan results still owed by the block, oldest first.
  scan_result_t expected_scans[$];
  int unsigned  mismatch_count;
  int unsigned  results_checked;
  int unsigned  items_sent;

  // Predictor state: byte window, fill level and the match latch.
  bit [7:0]    win[WIN];
  int unsigned fill;
  bit          seen;
  bit [2:0]    seen_type;

  // Directed streams. Every last byte carries a typed-in result:
  //   a lone 0xFF byte is too short to hold a package;
  //   nine bytes ending in ONE op are the shortest stream that can match;
  //   one extra length byte (0x40) shifts a word prefix whose operand is 5.
  stim_row_t directed_rows[22] = '{
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 3'd0}},
    '{8'h08, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h5F, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h53, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h35, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h5F, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h12, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h00, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h04, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h01, 1'b1, 1'b1, '{1'b1, 3'd1}},
    '{8'h08, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h5F, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h53, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h35, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h5F, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h12, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h40, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h00, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h02, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h0B, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h05, 1'b0, 1'b0, '{1'b0, 3'd0}},
    '{8'h00, 1'b1, 1'b1, '{1'b1, 3'd5}}
  };

  aml_sleep_type_scanner_core u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .sleep_type   (sleep_type)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Read past the window as zero, just as the hardware window would.
  function automatic bit [7:0] win_byte(int unsigned idx);
    return (idx < WIN) ? win[idx] : 8'h00;
  endfunction

  // Test the candidate at window offset o; rem counts the bytes from o to the
  // stream end, or is the window size while the stream goes on.
  function automatic bit s5_package_at(int unsigned o, int unsigned rem,
                                       output bit [2:0] stype);
    int unsigned extra;
    int unsigned p;
    bit [7:0]    v;
    bit [7:0]    operand;
    stype = 3'd0;
    if (rem <= 8) return 1'b0;
    if (win_byte(o) != NAME_OP || win_byte(o + 1) != CHAR_UNDERSCORE ||
        win_byte(o + 2) != CHAR_S || win_byte(o + 3) != CHAR_FIVE ||
        win_byte(o + 4) != CHAR_UNDERSCORE) return 1'b0;
    if (win_byte(o + 5) != PACKAGE_OP) return 1'b0;
    // Top two bits of the length byte count the extra length bytes.
    extra = win_byte(o + 6) >> 6;
    if (extra != 0 && 7 + extra >= rem) return 1'b0;
    p = 7 + extra;
    if (p >= rem) return 1'b0;
    // Skip the element count byte.
    p++;
    if (p >= rem) return 1'b0;
    v = win_byte(o + p);
    operand = win_byte(o + p + 1);
    if (v == BYTE_PREFIX && p + 1 < rem) begin
      stype = operand[2:0];
      return 1'b1;
    end
    if (v == ZERO_OP) begin
      stype = 3'd0;
      return 1'b1;
    end
    if (v == ONE_OP) begin
      stype = 3'd1;
      return 1'b1;
    end
    if (v == WORD_PREFIX && p + 2 < rem) begin
      stype = operand[2:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predictor by one accepted byte; return 1 when it closes a stream.
  function automatic bit scan_byte(bit [7:0] b, bit l, output scan_result_t res);
    bit [2:0] stype;
    res = '0;
    if (fill >= WIN) begin
      for (int i = 0; i < WIN - 1; i++) win[i] = win[i + 1];
      fill = WIN - 1;
    end
    win[fill] = b;
    fill++;
    if (!l) begin
      // Mid-stream: only the oldest candidate has all its bytes in hand.
      if (fill == WIN && !seen && s5_package_at(0, WIN, stype)) begin
        seen = 1'b1;
        seen_type = stype;
      end
      return 1'b0;
    end
    // End of stream: sweep what is left, oldest first, until something latches.
    for (int unsigned o = 0; o < fill && !seen; o++) begin
      if (s5_package_at(o, fill - o, stype)) begin
        seen = 1'b1;
        seen_type = stype;
      end
    end
    res.found = seen;
    res.stype = seen ? seen_type : 3'd0;
    // Drop all state so the next byte opens a new stream.
    foreach (win[i]) win[i] = 8'h00;
    fill = 0;
    seen = 1'b0;
    seen_type = 3'd0;
    return 1'b1;
  endfunction

  // Bias noise toward the bytes the scanner cares about.
  function automatic bit [7:0] noisy_byte();
    bit [7:0] picks[9];
    picks = '{NAME_OP, CHAR_UNDERSCORE, CHAR_S, CHAR_FIVE, PACKAGE_OP,
              BYTE_PREFIX, WORD_PREFIX, ZERO_OP, ONE_OP};
    if ($urandom_range(0, 2) == 0) return picks[$urandom_range(0, 8)];
    return 8'($urandom);
  endfunction

  // Mostly streams that hold one or two _S5_ packages with random content,
  // sometimes damaged or cut short; the rest pure noise.
  function automatic void build_stream(output byte_q_t s);
    int unsigned n;
    bit [7:0]    len_byte;
    bit [7:0]    v;
    bit [7:0]    head[6];
    bit [7:0]    values[5];
    s = {};
    if ($urandom_range(0, 99) < 75) begin
      repeat ($urandom_range(0, 8)) s.push_back(noisy_byte());
      repeat ($urandom_range(1, 2)) begin
        head = '{NAME_OP, CHAR_UNDERSCORE, CHAR_S, CHAR_FIVE, CHAR_UNDERSCORE, PACKAGE_OP};
        if ($urandom_range(0, 9) == 0) head[$urandom_range(0, 5)] = 8'($urandom);
        foreach (head[i]) s.push_back(head[i]);
        len_byte = 8'($urandom);
        s.push_back(len_byte);
        repeat (len_byte[7:6]) s.push_back(8'($urandom));
        s.push_back(8'($urandom));
        values = '{BYTE_PREFIX, ZERO_OP, ONE_OP, WORD_PREFIX, 8'($urandom)};
        v = values[$urandom_range(0, 4)];
        s.push_back(v);
        if (v == BYTE_PREFIX) s.push_back(8'($urandom));
        if (v == WORD_PREFIX) begin
          s.push_back(8'($urandom));
          s.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) s.push_back(noisy_byte());
      end
      // Cut the tail at times so a value or its operand runs into the stream end.
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        while (n > 0 && s.size() > 1) begin
          void'(s.pop_back());
          n--;
        end
      end
    end else begin
      repeat ($urandom_range(1, 24)) s.push_back(noisy_byte());
    end
  endfunction

  // Offer one byte after a random gap, hold it until accepted, then predict.
  task automatic send_byte(input bit [7:0] b, input bit l, input int unsigned gap_max,
                           input bit typed, input scan_result_t typed_res);
    int unsigned  gap;
    scan_result_t pred;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= l;
    do @(posedge clk); while (byte_stall);
    items_sent++;
    if (scan_byte(b, l, pred)) expected_scans.push_back(typed ? typed_res : pred);
  endtask

  // Sender: reset, directed table, then random streams, then drain.
  initial begin
    byte_q_t     stream;
    int unsigned gap_max;
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    data_byte  <= 8'h00;
    last_byte  <= 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    fill = 0;
    seen = 1'b0;
    seen_type = 3'd0;
    foreach (win[i]) win[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, 5,
                directed_rows[i].typed, directed_rows[i].res);

    // Keep about a third of the streams free of gaps so bytes go back to back.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      build_stream(stream);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      foreach (stream[i])
        send_byte(stream[i], i == stream.size() - 1, gap_max, 1'b0, '0);
    end
    byte_valid <= 1'b0;

    // Drain the owed results, then allow a few cycles for anything stray.
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_aml_sleep_type_scanner_core: PASS");
    end else begin
      $display("tb_aml_sleep_type_scanner_core: FAIL");
    end
    $finish;
  end

  // Receiver: stall a random count before each result, once for a long stretch
  // so the block holds a result and pushes back on the byte side.
  initial begin
    int unsigned  hold;
    scan_result_t exp_res;
    result_stall <= 1'b0;
    results_checked = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (results_checked == 3) hold = HOLD_OFF_CYCLES;
      else if ($urandom_range(0, 2) == 0) hold = 0;
      else hold = $urandom_range(0, 5);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      results_checked++;
      if (expected_scans.size() == 0) begin
        $display("%0t: unexpected result found %0d sleep_type %0d",
                 $time, found, sleep_type);
        mismatch_count++;
      end else begin
        exp_res = expected_scans.pop_front();
        if (found !== exp_res.found) begin
          $display("%0t: found mismatch expected %0d actual %0d",
                   $time, exp_res.found, found);
          mismatch_count++;
        end
        if (sleep_type !== exp_res.stype) begin
          $display("%0t: sleep_type mismatch expected %0d actual %0d",
                   $time, exp_res.stype, sleep_type);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    #2_000_000;
    $display("tb_aml_sleep_type_scanner_core: FAIL");
    $finish;
  end

endmodule
